>>> design/psu_pkg.sv
// shared constants, types and filter codes for the png scanline unfilter
package psu_pkg;

	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int COL_W  = $clog2(MAX_ROW_BYTES + 1);
	localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
	localparam int TAP_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int BPP_W  = 4;

	localparam logic [7:0] FT_NONE  = 8'd0;
	localparam logic [7:0] FT_SUB   = 8'd1;
	localparam logic [7:0] FT_UP    = 8'd2;
	localparam logic [7:0] FT_AVG   = 8'd3;
	localparam logic [7:0] FT_PAETH = 8'd4;

	// neighbors of the current byte: left, up, upper left
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} nbr_t;

endpackage

>>> design/psu_ram.sv
// generic single write, single read ram with registered read data
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/psu_window.sv
// shift window of recent bytes with a selectable tap
module psu_window
	import psu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic [7:0]       din,
	input  logic [TAP_W-1:0] tap_idx,
	output logic [7:0]       dout
);

	logic [7:0] win_q [MAX_PIXEL_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				win_q[i] <= 8'd0;
			end
		end else if (shift_en) begin
			win_q[0] <= din;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	assign dout = win_q[tap_idx];

endmodule

>>> design/psu_predict.sv
// filter predictor and reconstruction sum
module psu_predict
	import psu_pkg::*;
(
	input  logic [7:0] filt_byte,
	input  logic [7:0] row_filter,
	input  nbr_t       nbr,
	output logic [7:0] recon_byte,
	output logic       bad_filter
);

	logic [9:0] pa, pb, pc;
	logic [9:0] sum_ab, two_c;
	logic [8:0] avg_sum;
	logic [7:0] paeth, pred;

	always_comb begin
		pa     = (nbr.b > nbr.c) ? 10'(nbr.b - nbr.c) : 10'(nbr.c - nbr.b);
		pb     = (nbr.a > nbr.c) ? 10'(nbr.a - nbr.c) : 10'(nbr.c - nbr.a);
		sum_ab = 10'(nbr.a) + 10'(nbr.b);
		two_c  = {1'b0, nbr.c, 1'b0};
		pc     = (sum_ab > two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
		priority if (pa <= pb && pa <= pc) begin
			paeth = nbr.a;
		end else if (pb <= pc) begin
			paeth = nbr.b;
		end else begin
			paeth = nbr.c;
		end
	end

	always_comb begin
		avg_sum = 9'(nbr.a) + 9'(nbr.b);
		unique case (row_filter)
			FT_SUB:   pred = nbr.a;
			FT_UP:    pred = nbr.b;
			FT_AVG:   pred = avg_sum[8:1];
			FT_PAETH: pred = paeth;
			default:  pred = 8'd0;
		endcase
	end

	assign recon_byte = filt_byte + pred;
	assign bad_filter = (row_filter > FT_PAETH);

endmodule

>>> design/png_scanline_unfilter_core.sv
// top level of the png scanline unfilter: control, line buffer and output register
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | input     | in_valid / in_stall   | filt_byte, row_filter, row_start,
//           |           |                       | first_row
//   out     | output    | out_valid / out_stall | recon_byte, bad_filter
//   cfg     | input     | cfg_wr_en             | cfg_wr_data (bytes_per_pixel)
//
// one word in and one word out per clock when neither side stalls; out_valid rises after
// the accept via stage 1 (line buffer read at accept edge) and predictor into output register
// the rate is set by the line buffer: one read and one write port each cycle
// reset clears control, column, windows and pixel size (1); the line buffer keeps no reset
// in_stall rises only when stage 1 holds a word and the output register is full and stalled
module png_scanline_unfilter_core
	import psu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input word channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       filt_byte,
	input  logic [7:0]       row_filter,
	input  logic             row_start,
	input  logic             first_row,
	// result word channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       recon_byte,
	output logic             bad_filter,
	// configuration
	input  logic             cfg_wr_en,
	input  logic [BPP_W-1:0] cfg_wr_data
);

	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_ROW_BYTES);
	localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(MAX_PIXEL_BYTES);

	// configuration and column state
	logic [BPP_W-1:0] bpp_q;
	logic [BPP_W-1:0] bpp_eff;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] in_col;
	logic             in_col_ok;

	// stage 1: word waiting on its line buffer read
	logic             valid_s1;
	logic [7:0]       filt_s1;
	logic [7:0]       ftype_s1;
	logic             first_s1;
	logic [COL_W-1:0] col_s1;
	logic             col_ok_s1;
	logic             byp_s1;
	logic [7:0]       byp_data_s1;

	// output register
	logic             out_valid_q;
	logic [7:0]       recon_q;
	logic             bad_q;

	logic             in_acc;
	logic             adv_s1;
	logic             wr_en;
	logic [7:0]       rd_data;
	logic [7:0]       up_byte;
	logic [7:0]       left_tap, ul_tap;
	logic             left_ok;
	logic [TAP_W-1:0] tap_idx;
	nbr_t             nbr;
	logic [7:0]       recon_s1;
	logic             bad_s1;

	// stage 1 moves on when the output register is free or being emptied
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	// column of the incoming word; sticks at the end once the row is too long
	assign in_col    = row_start ? '0 : col_q;
	assign in_col_ok = (in_col < COL_MAX);

	// pixel size clamp: zero acts as one, large values act as the window depth
	always_comb begin
		priority if (bpp_q == '0) begin
			bpp_eff = BPP_W'(1);
		end else if (bpp_q > BPP_MAX) begin
			bpp_eff = BPP_MAX;
		end else begin
			bpp_eff = bpp_q;
		end
	end
	assign tap_idx = TAP_W'(bpp_eff - BPP_W'(1));

	// line buffer write of the word leaving stage 1
	assign wr_en = adv_s1 && col_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_W'(1);
		end else if (cfg_wr_en) begin
			bpp_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				col_q <= in_col_ok ? (in_col + COL_W'(1)) : in_col;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload; a one-byte row reads the entry that the word ahead writes now
	always_ff @(posedge clk) begin
		if (in_acc) begin
			filt_s1     <= filt_byte;
			ftype_s1    <= row_filter;
			first_s1    <= first_row;
			col_s1      <= in_col;
			col_ok_s1   <= in_col_ok;
			byp_s1      <= wr_en && (col_s1 == in_col);
			byp_data_s1 <= recon_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			recon_q <= recon_s1;
			bad_q   <= bad_s1;
		end
	end

	psu_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_prior_row (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_s1[ADDR_W-1:0]),
		.wr_data (recon_s1),
		.rd_en   (in_acc && in_col_ok),
		.rd_addr (in_col[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// up neighbor is zero on a first row and past the end of the buffer
	always_comb begin
		priority if (first_s1 || !col_ok_s1) begin
			up_byte = 8'd0;
		end else if (byp_s1) begin
			up_byte = byp_data_s1;
		end else begin
			up_byte = rd_data;
		end
	end

	psu_window u_left_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (adv_s1),
		.din      (recon_s1),
		.tap_idx  (tap_idx),
		.dout     (left_tap)
	);

	psu_window u_ul_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (adv_s1),
		.din      (up_byte),
		.tap_idx  (tap_idx),
		.dout     (ul_tap)
	);

	// left edge of the row: left and upper left read as zero
	assign left_ok = (col_s1 >= COL_W'(bpp_eff));

	always_comb begin
		nbr.a = left_ok ? left_tap : 8'd0;
		nbr.b = up_byte;
		nbr.c = left_ok ? ul_tap : 8'd0;
	end

	psu_predict u_predict (
		.filt_byte  (filt_s1),
		.row_filter (ftype_s1),
		.nbr        (nbr),
		.recon_byte (recon_s1),
		.bad_filter (bad_s1)
	);

	assign out_valid  = out_valid_q;
	assign recon_byte = recon_q;
	assign bad_filter = bad_q;

endmodule
